// File: sv/tpd_pkg.sv
// tpd_pkg: shared widths, mode codes and the root-cell transaction type
// for the tsplib pair distance block; no dependencies
`default_nettype none

package tpd_pkg;

  // default fraction bits of the coordinates
  localparam int FRAC_BITS_DEF = 8;

  // fixed field widths
  localparam int COORD_W = 31;
  localparam int DIFF_W  = COORD_W + 1;
  localparam int SQ_W    = 2 * COORD_W;
  localparam int SUM_W   = SQ_W + 1;
  localparam int N_W     = SUM_W + 2;
  localparam int ROOT_W  = 33;
  localparam int K_W     = 4;
  localparam int KV_W    = ROOT_W + K_W;
  localparam int TRIAL_W = KV_W + ROOT_W + 2;
  localparam int DIST_W  = 24;
  localparam int FIN_W   = ROOT_W + 2;

  // scale of the pseudo-euclidean rule
  localparam int ATT_SCALE = 10;

  // distance rules, the last code is unused and gives zero
  typedef enum logic [1:0] {
    MODE_EUC    = 2'd0,
    MODE_ATT    = 2'd1,
    MODE_CEIL   = 2'd2,
    MODE_UNUSED = 2'd3
  } mode_t;

  // partial root state handed from cell to cell
  typedef struct packed {
    logic [N_W-1:0]    rem;
    logic [KV_W-1:0]   kv;
    logic [ROOT_W-1:0] root;
  } root_item_t;

endpackage

`default_nettype wire

// File: sv/tpd_front.sv
// tpd_front: coordinate differences, absolute values, squares and the
// radicand for the root chain; depends on tpd_pkg
`default_nettype none

module tpd_front import tpd_pkg::*; (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      adv,
  input  wire logic                      euc,
  input  wire logic                      in_valid,
  input  wire logic signed [COORD_W-1:0] ax,
  input  wire logic signed [COORD_W-1:0] ay,
  input  wire logic signed [COORD_W-1:0] bx,
  input  wire logic signed [COORD_W-1:0] by,
  output logic                           out_valid,
  output logic [N_W-1:0]                 out_n
);

  logic signed [DIFF_W-1:0] diff_x, diff_y;
  logic [DIFF_W-1:0]        neg_x, neg_y;
  logic [COORD_W-1:0]       abs_x, abs_y;
  logic [SQ_W-1:0]          sq_x, sq_y;
  logic                     diff_valid, abs_valid, sq_valid;
  logic [SUM_W-1:0]         sum_sq;
  logic [N_W-1:0]           n_next;

  // magnitude of each difference, fits the coordinate width
  assign neg_x = -diff_x;
  assign neg_y = -diff_y;

  // squared distance, scaled by four for the rounded rule
  assign sum_sq = SUM_W'(sq_x) + SUM_W'(sq_y);
  assign n_next = euc ? {sum_sq, 2'b00} : {2'b00, sum_sq};

  // valid bits of the four stages
  always_ff @(posedge clk) begin
    if (rst) begin
      diff_valid <= 1'b0;
      abs_valid  <= 1'b0;
      sq_valid   <= 1'b0;
      out_valid  <= 1'b0;
    end else if (adv) begin
      diff_valid <= in_valid;
      abs_valid  <= diff_valid;
      sq_valid   <= abs_valid;
      out_valid  <= sq_valid;
    end
  end

  // payload of the four stages
  always_ff @(posedge clk) begin
    if (adv) begin
      diff_x <= DIFF_W'(ax) - DIFF_W'(bx);
      diff_y <= DIFF_W'(ay) - DIFF_W'(by);
      abs_x  <= diff_x[DIFF_W-1] ? neg_x[COORD_W-1:0] : diff_x[COORD_W-1:0];
      abs_y  <= diff_y[DIFF_W-1] ? neg_y[COORD_W-1:0] : diff_y[COORD_W-1:0];
      sq_x   <= SQ_W'(abs_x) * SQ_W'(abs_x);
      sq_y   <= SQ_W'(abs_y) * SQ_W'(abs_y);
      out_n  <= n_next;
    end
  end

endmodule

`default_nettype wire

// File: sv/tpd_cell.sv
// tpd_cell: one digit of the scaled integer square root, deciding root
// bit BIT of the largest v with k*v*v <= n; depends on tpd_pkg
`default_nettype none

module tpd_cell import tpd_pkg::*; #(
  parameter int BIT = 0
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       adv,
  input  wire logic       att,
  input  wire logic       in_valid,
  input  wire root_item_t in_item,
  output logic            out_valid,
  output root_item_t      out_item
);

  logic [K_W-1:0]     k;
  logic [TRIAL_W-1:0] trial, rem_ext;
  logic               fits;

  // k*((v + 2^BIT)^2 - v^2) = (k*v << (BIT+1)) + (k << 2*BIT)
  assign k       = att ? K_W'(ATT_SCALE) : K_W'(1);
  assign trial   = (TRIAL_W'(in_item.kv) << (BIT + 1)) + (TRIAL_W'(k) << (2 * BIT));
  assign rem_ext = TRIAL_W'(in_item.rem);
  assign fits    = rem_ext >= trial;

  // valid bit
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= in_valid;
    end
  end

  // keep the bit when the trial fits under the remainder
  always_ff @(posedge clk) begin
    if (adv) begin
      if (fits) begin
        out_item.rem  <= in_item.rem - trial[N_W-1:0];
        out_item.kv   <= in_item.kv + (KV_W'(k) << BIT);
        out_item.root <= in_item.root | (ROOT_W'(1) << BIT);
      end else begin
        out_item <= in_item;
      end
    end
  end

  // the scaled root always tracks the root
  a_kv_tracks_root: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_item.kv == KV_W'(out_item.root) * KV_W'(k)))
    else $error("tpd_cell: scaled root out of step with root");

endmodule

`default_nettype wire

// File: sv/tsplib_pair_distance.sv
// tsplib_pair_distance: top level with input skid stage, front end, root
// cell chain and the rounding output stage; depends on tpd_pkg, tpd_front, tpd_cell
`default_nettype none

// Integer TSPLIB distance of two fixed-point points (EUC_2D, ATT, CEIL_2D
// chosen by distance_mode; the unused code gives 0, results above 2^24-1
// saturate). One pair is taken every cycle while pair_stall is low, and each
// result passes four front-end stages (difference, magnitude, square, sum), a
// chain of 33 root cells deciding one root bit each, and the output register. A
// stall on the result side freezes the whole pipeline; a one-deep skid stage
// at the input keeps pair_stall registered. Write distance_mode only while
// no transaction is in flight.
module tsplib_pair_distance import tpd_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      distance_mode_we,
  input  wire logic [1:0]                distance_mode_wdata,
  input  wire logic                      pair_valid,
  output logic                           pair_stall,
  input  wire logic signed [COORD_W-1:0] first_x,
  input  wire logic signed [COORD_W-1:0] first_y,
  input  wire logic signed [COORD_W-1:0] second_x,
  input  wire logic signed [COORD_W-1:0] second_y,
  output logic                           distance_valid,
  input  wire logic                      distance_stall,
  output logic [DIST_W-1:0]              distance
);

  logic [1:0]                distance_mode;
  logic                      adv;
  logic                      skid_full;
  logic signed [COORD_W-1:0] skid_ax, skid_ay, skid_bx, skid_by;
  logic signed [COORD_W-1:0] src_ax, src_ay, src_bx, src_by;
  logic                      src_valid;
  logic                      front_valid;
  logic [N_W-1:0]            front_n;
  logic                      is_euc, is_att;
  logic                      chain_valid [ROOT_W+1];
  root_item_t                chain_item  [ROOT_W+1];
  logic                      rem_nz;
  logic [FIN_W-1:0]          euc_sum, ceil_sum, fin_t;
  logic [DIST_W-1:0]         distance_next;

  // mode register
  always_ff @(posedge clk) begin
    if (rst) begin
      distance_mode <= MODE_EUC;
    end else if (distance_mode_we) begin
      distance_mode <= distance_mode_wdata;
    end
  end

  assign is_euc = distance_mode == MODE_EUC;
  assign is_att = distance_mode == MODE_ATT;

  // the pipeline moves whenever the output register is free or taken
  assign adv        = !distance_valid || !distance_stall;
  assign pair_stall = skid_full;

  // input skid stage
  always_ff @(posedge clk) begin
    if (rst) begin
      skid_full <= 1'b0;
    end else if (adv) begin
      skid_full <= 1'b0;
    end else if (pair_valid && !skid_full) begin
      skid_full <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!adv && !skid_full) begin
      skid_ax <= first_x;
      skid_ay <= first_y;
      skid_bx <= second_x;
      skid_by <= second_y;
    end
  end

  assign src_valid = skid_full || pair_valid;
  assign src_ax    = skid_full ? skid_ax : first_x;
  assign src_ay    = skid_full ? skid_ay : first_y;
  assign src_bx    = skid_full ? skid_bx : second_x;
  assign src_by    = skid_full ? skid_by : second_y;

  // squared distance front end
  tpd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .euc       (is_euc),
    .in_valid  (src_valid),
    .ax        (src_ax),
    .ay        (src_ay),
    .bx        (src_bx),
    .by        (src_by),
    .out_valid (front_valid),
    .out_n     (front_n)
  );

  // root chain, most significant bit first
  assign chain_valid[0]     = front_valid;
  assign chain_item[0].rem  = front_n;
  assign chain_item[0].kv   = '0;
  assign chain_item[0].root = '0;

  for (genvar i = 0; i < ROOT_W; i++) begin : g_cell
    tpd_cell #(
      .BIT (ROOT_W - 1 - i)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .adv       (adv),
      .att       (is_att),
      .in_valid  (chain_valid[i]),
      .in_item   (chain_item[i]),
      .out_valid (chain_valid[i+1]),
      .out_item  (chain_item[i+1])
    );
  end

  // rounding: nearest for euclidean, ceiling of the root then of the unit otherwise
  assign rem_nz   = |chain_item[ROOT_W].rem;
  assign euc_sum  = FIN_W'(chain_item[ROOT_W].root) + (FIN_W'(1) << FRAC_BITS);
  assign ceil_sum = FIN_W'(chain_item[ROOT_W].root) + (FIN_W'(1) << FRAC_BITS)
                    - FIN_W'(!rem_nz);

  always_comb begin
    case (distance_mode)
      MODE_EUC:  fin_t = euc_sum >> (FRAC_BITS + 1);
      MODE_ATT:  fin_t = ceil_sum >> FRAC_BITS;
      MODE_CEIL: fin_t = ceil_sum >> FRAC_BITS;
      default:   fin_t = '0;
    endcase
    if (|fin_t[FIN_W-1:DIST_W]) begin
      distance_next = '1;
    end else begin
      distance_next = fin_t[DIST_W-1:0];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      distance_valid <= 1'b0;
    end else if (adv) begin
      distance_valid <= chain_valid[ROOT_W];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      distance <= distance_next;
    end
  end

  // skid stage fills only while the pipeline is frozen
  a_skid_on_freeze: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_full) |-> !$past(adv))
    else $error("tsplib_pair_distance: skid filled while pipeline moving");

  // a full skid stage always drains on the next advance
  a_skid_drains: assert property (@(posedge clk) disable iff (rst)
    (skid_full && adv) |=> !skid_full)
    else $error("tsplib_pair_distance: skid held across an advance");

  // the unused mode code yields zero
  a_unused_mode_zero: assert property (@(posedge clk) disable iff (rst)
    (distance_valid && distance_mode == MODE_UNUSED) |-> (distance == '0))
    else $error("tsplib_pair_distance: non-zero distance for unused mode");

endmodule

`default_nettype wire

// File: bench/tpd_distance_checker.sv
`timescale 1ns / 100ps
// tpd_distance_checker: watches the pair and distance channels of the tsplib
// pair distance block, predicts each distance and compares; depends on tpd_pkg
module tpd_distance_checker import tpd_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      distance_mode_we,
  input  logic [1:0]                distance_mode_wdata,
  input  logic                      pair_valid,
  input  logic                      pair_stall,
  input  logic signed [COORD_W-1:0] first_x,
  input  logic signed [COORD_W-1:0] first_y,
  input  logic signed [COORD_W-1:0] second_x,
  input  logic signed [COORD_W-1:0] second_y,
  input  logic                      distance_valid,
  input  logic                      distance_stall,
  input  logic [DIST_W-1:0]         distance,
  output int                        error_count,
  output int                        distances_pending
);

  localparam logic [63:0] DIST_LIMIT = {{(64-DIST_W){1'b0}}, {DIST_W{1'b1}}};

  logic [1:0]        dist_mode;
  logic [DIST_W-1:0] expected_distances [$];

  // bit-by-bit floor square root of a 64-bit value
  function automatic logic [63:0] floor_root(input logic [63:0] n);
    logic [63:0] rem;
    logic [63:0] res;
    logic [63:0] probe;
    rem   = n;
    res   = 64'd0;
    probe = 64'd1 << 62;
    while (probe > rem) probe = probe >> 2;
    while (probe != 64'd0) begin
      if (rem >= res + probe) begin
        rem = rem - (res + probe);
        res = (res >> 1) + probe;
      end else begin
        res = res >> 1;
      end
      probe = probe >> 2;
    end
    return res;
  endfunction

  // integer distance of one point pair under the given rule
  function automatic logic [DIST_W-1:0] tsplib_distance(
    input logic [1:0]                mode,
    input logic signed [COORD_W-1:0] ax,
    input logic signed [COORD_W-1:0] ay,
    input logic signed [COORD_W-1:0] bx,
    input logic signed [COORD_W-1:0] by
  );
    longint      sx;
    longint      sy;
    logic [63:0] dx;
    logic [63:0] dy;
    logic [63:0] sq;
    logic [63:0] unit;
    logic [63:0] root;
    logic [63:0] t;
    sx   = longint'(ax) - longint'(bx);
    sy   = longint'(ay) - longint'(by);
    dx   = (sx < 0) ? -sx : sx;
    dy   = (sy < 0) ? -sy : sy;
    sq   = dx * dx + dy * dy;
    unit = 64'd1 << FRAC_BITS;
    case (mode)
      MODE_EUC: begin
        // twice the root, floored, then rounded to the nearest unit
        root = floor_root(sq);
        t    = 64'd2 * root + ((sq > root * root + root) ? 64'd1 : 64'd0);
        t    = (t + unit) >> (FRAC_BITS + 1);
      end
      MODE_ATT: begin
        // smallest u with scale * u^2 >= sq, then ceiling to a unit
        root = floor_root(sq / ATT_SCALE);
        if (ATT_SCALE * root * root < sq) root = root + 64'd1;
        t = (root + unit - 64'd1) >> FRAC_BITS;
      end
      MODE_CEIL: begin
        root = floor_root(sq);
        if (root * root != sq) root = root + 64'd1;
        t = (root + unit - 64'd1) >> FRAC_BITS;
      end
      default: begin
        t = 64'd0;
      end
    endcase
    if (t > DIST_LIMIT) t = DIST_LIMIT;
    return t[DIST_W-1:0];
  endfunction

  initial error_count = 0;

  // track the mode, queue a prediction per pair, compare each distance
  always @(posedge clk) begin : watch
    logic [DIST_W-1:0] want;
    if (rst) begin
      dist_mode = MODE_EUC;
      expected_distances.delete();
    end else begin
      if (distance_mode_we) dist_mode = distance_mode_wdata;
      if (pair_valid && !pair_stall) begin
        expected_distances.push_back(
          tsplib_distance(dist_mode, first_x, first_y, second_x, second_y));
      end
      if (distance_valid && !distance_stall) begin
        if (expected_distances.size() == 0) begin
          $error("distance: expected none, actual %0d", distance);
          error_count++;
        end else begin
          want = expected_distances.pop_front();
          if (distance !== want) begin
            $error("distance: expected %0d, actual %0d", want, distance);
            error_count++;
          end
        end
      end
    end
    distances_pending = expected_distances.size();
  end

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 100ps
// tb_top: stimulus, clock, reset and verdict for tsplib_pair_distance;
// depends on tpd_pkg, the block itself and tpd_distance_checker
module tb_top;
  import tpd_pkg::*;

  localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};
  localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_SLACK = 48;
  localparam int BATCH       = 150;

  logic                      clk;
  logic                      rst;
  logic                      distance_mode_we;
  logic [1:0]                distance_mode_wdata;
  logic                      pair_valid;
  logic                      pair_stall;
  logic signed [COORD_W-1:0] first_x;
  logic signed [COORD_W-1:0] first_y;
  logic signed [COORD_W-1:0] second_x;
  logic signed [COORD_W-1:0] second_y;
  logic                      distance_valid;
  logic                      distance_stall;
  logic [DIST_W-1:0]         distance;
  int                        error_count;
  int                        distances_pending;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_asks     = 0;
  int hold_served   = 0;
  int hold_left     = 0;

  tsplib_pair_distance DUT (
    .clk                 (clk),
    .rst                 (rst),
    .distance_mode_we    (distance_mode_we),
    .distance_mode_wdata (distance_mode_wdata),
    .pair_valid          (pair_valid),
    .pair_stall          (pair_stall),
    .first_x             (first_x),
    .first_y             (first_y),
    .second_x            (second_x),
    .second_y            (second_y),
    .distance_valid      (distance_valid),
    .distance_stall      (distance_stall),
    .distance            (distance)
  );

  tpd_distance_checker checker_i (
    .clk                 (clk),
    .rst                 (rst),
    .distance_mode_we    (distance_mode_we),
    .distance_mode_wdata (distance_mode_wdata),
    .pair_valid          (pair_valid),
    .pair_stall          (pair_stall),
    .first_x             (first_x),
    .first_y             (first_y),
    .second_x            (second_x),
    .second_y            (second_y),
    .distance_valid      (distance_valid),
    .distance_stall      (distance_stall),
    .distance            (distance),
    .error_count         (error_count),
    .distances_pending   (distances_pending)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  initial begin
    #2000000;
    $display("Verification failed");
    $finish;
  end

  // receiver: random stall, or a long hold when one is asked for
  initial begin
    distance_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        distance_stall = 1'b1;
        hold_left--;
      end else if (hold_served != hold_asks) begin
        hold_served++;
        hold_left      = HOLD_CYCLES - 1;
        distance_stall = 1'b1;
      end else begin
        distance_stall = ($urandom_range(0, 99) < recv_idle_pct);
      end
    end
  end

  function automatic logic signed [COORD_W-1:0] rand_coord();
    logic [31:0] r;
    r = $urandom();
    return r[COORD_W-1:0];
  endfunction

  function automatic logic signed [COORD_W-1:0] edge_coord();
    case ($urandom_range(0, 3))
      0:       return COORD_MIN;
      1:       return COORD_MAX;
      2:       return '0;
      default: return '1;
    endcase
  endfunction

  // offer one pair after a random gap and hold it until taken
  task automatic send_pair(input logic signed [COORD_W-1:0] ax, ay, bx, by);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      pair_valid = 1'b0;
      @(negedge clk);
    end
    pair_valid = 1'b1;
    first_x    = ax;
    first_y    = ay;
    second_x   = bx;
    second_y   = by;
    do @(posedge clk); while (pair_stall);
  endtask

  // stop offering and wait until every queued distance has come out
  task automatic wait_for_results();
    @(negedge clk);
    pair_valid = 1'b0;
    while (distances_pending != 0) @(negedge clk);
  endtask

  // change the rule only once the pipeline has emptied
  task automatic set_distance_mode(input logic [1:0] code);
    wait_for_results();
    repeat (DRAIN_SLACK) @(negedge clk);
    distance_mode_we    = 1'b1;
    distance_mode_wdata = code;
    @(negedge clk);
    distance_mode_we = 1'b0;
  endtask

  initial begin
    logic signed [COORD_W-1:0] ax;
    logic signed [COORD_W-1:0] ay;
    logic signed [COORD_W-1:0] bx;
    logic signed [COORD_W-1:0] by;
    logic [1:0]                mode_order [4];
    int                        small_a;
    int                        small_b;

    rst                 = 1'b1;
    distance_mode_we    = 1'b0;
    distance_mode_wdata = MODE_EUC;
    pair_valid          = 1'b0;
    first_x             = '0;
    first_y             = '0;
    second_x            = '0;
    second_y            = '0;
    mode_order[0]       = MODE_EUC;
    mode_order[1]       = MODE_ATT;
    mode_order[2]       = MODE_CEIL;
    mode_order[3]       = MODE_UNUSED;

    repeat (10) @(negedge clk);
    rst = 1'b0;

    // directed: same point, widest spans, half-unit rounding, tiny steps
    for (int m = 0; m < 4; m++) begin
      set_distance_mode(mode_order[m]);
      send_pair('0, '0, '0, '0);
      send_pair(COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX);
      send_pair(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX);
      send_pair(COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX);
      send_pair('0, '0, 31'sd128, '0);
      send_pair(31'sd1, '0, '0, -31'sd1);
    end

    // random: three idling phases, every rule in each
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin send_idle_pct = 10; recv_idle_pct = 50; end
        1: begin send_idle_pct = 50; recv_idle_pct = 10; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      for (int sub = 0; sub < 4; sub++) begin
        set_distance_mode(mode_order[(sub + phase) % 4]);
        // long receiver hold while pairs keep coming
        if (phase == 2 && sub == 0) hold_asks++;
        for (int i = 0; i < BATCH; i++) begin
          if (sub == 1 && i == BATCH / 2) wait_for_results();
          case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
              ax = rand_coord(); ay = rand_coord();
              bx = rand_coord(); by = rand_coord();
            end
            4, 5, 6: begin
              small_a = $urandom_range(0, 4095); small_b = $urandom_range(0, 4095);
              ax = COORD_W'(small_a - 2048); ay = COORD_W'(small_b - 2048);
              small_a = $urandom_range(0, 4095); small_b = $urandom_range(0, 4095);
              bx = COORD_W'(small_a - 2048); by = COORD_W'(small_b - 2048);
            end
            7: begin
              // nearby points: flip a few low bits
              ax = rand_coord(); ay = rand_coord();
              bx = ax ^ COORD_W'($urandom_range(0, 1023));
              by = ay ^ COORD_W'($urandom_range(0, 1023));
            end
            8: begin
              ax = edge_coord(); ay = edge_coord();
              bx = edge_coord(); by = edge_coord();
            end
            default: begin
              ax = rand_coord(); ay = rand_coord();
              bx = ax; by = ay;
            end
          endcase
          send_pair(ax, ay, bx, by);
        end
      end
    end

    wait_for_results();
    repeat (DRAIN_SLACK) @(negedge clk);
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
